// File: rtl/ulbp_pkg.sv
// Shared types, constants and the uniform pattern lookup table for the
// uniform 3x3 LBP unit. No dependencies.
package ulbp_pkg;

	// default frame limits
	localparam int MAX_COLS_DEF = 1024;
	localparam int MAX_ROWS_DEF = 1024;

	// field widths
	localparam int CFG_W     = 11;
	localparam int PIX_W     = 8;
	localparam int IDX_W     = 6;
	localparam int POS_W     = 10;
	localparam int REG_IDX_W = 1;

	// register map
	localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_COLS = 1'b1;

	// register reset values
	localparam logic [CFG_W-1:0] ROWS_RST = 11'd80;
	localparam logic [CFG_W-1:0] COLS_RST = 11'd160;

	// first row whose top neighbour comes from the older line buffer
	localparam int TOP_ROW_MIN = 2;

	// most circular transitions a uniform pattern may have
	localparam int MAX_TRANS = 2;

	// result slots of one pixel, in output order
	localparam int SLOT_UP_MID = 0;
	localparam int SLOT_UP_END = 1;
	localparam int SLOT_LO_MID = 2;
	localparam int SLOT_LO_END = 3;
	localparam int NUM_SLOTS   = 4;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [IDX_W-1:0] uni_lut_t [256];

	// control flags of the pixel held in the result stage
	typedef struct packed {
		logic [NUM_SLOTS-1:0] slot;
		logic                 col_nz;
		logic                 row_nz;
		logic                 frame_last;
	} item_ctl_t;

	function automatic logic is_uniform(logic [7:0] code);
		logic [7:0] x;
		x = code ^ {code[6:0], code[7]};
		return $countones(x) <= MAX_TRANS;
	endfunction

	// uniform codes numbered from one in increasing code order, others zero
	function automatic uni_lut_t build_uni_lut();
		uni_lut_t         lut;
		logic [IDX_W-1:0] n;
		n = '0;
		for (int i = 0; i < 256; i++) begin
			if (is_uniform(8'(i))) begin
				n      = n + 1'b1;
				lut[i] = n;
			end else begin
				lut[i] = '0;
			end
		end
		return lut;
	endfunction

	localparam uni_lut_t UNI_LUT = build_uni_lut();

endpackage

// File: rtl/ulbp_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ulbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and read, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/ulbp_emit.sv
// Window registers, result slot sequencer and output register of the LBP unit.
// Depends on ulbp_pkg.
module ulbp_emit #(
	parameter int MAX_COLS = ulbp_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = ulbp_pkg::MAX_ROWS_DEF,
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s1_valid,
	input  ulbp_pkg::item_ctl_t          s1_ctl,
	input  logic [RW-1:0]                s1_row,
	input  logic [CW-1:0]                s1_col,
	input  ulbp_pkg::pix_t               s1_top,
	input  ulbp_pkg::pix_t               s1_mid,
	input  ulbp_pkg::pix_t               s1_px,
	output logic                         s1_fire,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ulbp_pkg::IDX_W-1:0]   lbp_index,
	output logic [ulbp_pkg::POS_W-1:0]   out_row,
	output logic [ulbp_pkg::POS_W-1:0]   out_col,
	output logic                         frame_end
);

	import ulbp_pkg::*;

	pix_t                 win_q [3][3];
	pix_t                 win_new [3][3];
	logic [NUM_SLOTS-1:0] done_q;
	logic [NUM_SLOTS-1:0] remaining;
	logic [NUM_SLOTS-1:0] pick;
	logic [NUM_SLOTS-1:0] rest;
	logic                 out_free;
	logic                 emit;
	logic                 upper;
	logic                 right;
	pix_t                 rt_t [3];
	pix_t                 rt_m [3];
	pix_t                 rt_b [3];
	logic [1:0]           li;
	logic [1:0]           ci;
	logic [1:0]           ri;
	pix_t                 cen;
	logic [7:0]           code;
	logic [RW-1:0]        res_row;
	logic [CW-1:0]        res_col;
	logic                 out_valid_q;

	// window after this pixel: refill at row start, else shift left
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (!s1_ctl.col_nz || j == 2) begin
				win_new[0][j] = s1_top;
				win_new[1][j] = s1_mid;
				win_new[2][j] = s1_px;
			end else begin
				win_new[0][j] = win_q[0][j+1];
				win_new[1][j] = win_q[1][j+1];
				win_new[2][j] = win_q[2][j+1];
			end
		end
	end

	// slot sequencing: lowest pending slot goes next
	assign out_free  = !out_valid_q || out_ready;
	assign remaining = s1_valid ? (s1_ctl.slot & ~done_q) : '0;
	assign pick      = remaining & (~remaining + 1'b1);
	assign rest      = remaining & ~pick;
	assign emit      = out_free && (remaining != '0);
	assign s1_fire   = s1_valid && ((remaining == '0) || (emit && rest == '0));

	// row and column selection for the picked slot
	always_comb begin
		upper = pick[SLOT_UP_MID] | pick[SLOT_UP_END];
		right = pick[SLOT_UP_END] | pick[SLOT_LO_END];
		for (int j = 0; j < 3; j++) begin
			rt_b[j] = win_new[2][j];
			if (upper) begin
				rt_t[j] = win_new[0][j];
				rt_m[j] = win_new[1][j];
			end else begin
				rt_t[j] = s1_ctl.row_nz ? win_new[1][j] : win_new[2][j];
				rt_m[j] = win_new[2][j];
			end
		end
		if (right) begin
			li = s1_ctl.col_nz ? 2'd1 : 2'd2;
			ci = 2'd2;
			ri = 2'd2;
		end else begin
			li = 2'd0;
			ci = 2'd1;
			ri = 2'd2;
		end
		res_row = upper ? (s1_row - 1'b1) : s1_row;
		res_col = right ? s1_col : (s1_col - 1'b1);
	end

	// neighbour compares, top-left is the msb, going anticlockwise
	always_comb begin
		cen     = rt_m[ci];
		code[7] = rt_t[li] >= cen;
		code[6] = rt_m[li] >= cen;
		code[5] = rt_b[li] >= cen;
		code[4] = rt_b[ci] >= cen;
		code[3] = rt_b[ri] >= cen;
		code[2] = rt_m[ri] >= cen;
		code[1] = rt_t[ri] >= cen;
		code[0] = rt_t[ci] >= cen;
	end

	// control state: window, emitted slots, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else begin
			if (s1_fire) begin
				done_q <= '0;
				win_q  <= win_new;
			end else if (emit) begin
				done_q <= done_q | pick;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			lbp_index <= UNI_LUT[code];
			out_row   <= POS_W'(res_row);
			out_col   <= POS_W'(res_col);
			frame_end <= s1_ctl.frame_last && (rest == '0);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/uniform_lbp_3x3_unit.sv
// Uniform 3x3 LBP unit: line buffer memory, raster position, result stage.
// A pixel that completes a window is registered in the result stage, its first result
// then in the output register; more results follow one a cycle while out_ready holds.
// Throughput: likewise one pixel a cycle, but a pixel holds the result stage until
// the single result port has taken its results: up to two at row ends and on the last
// row, up to four for a frame's last pixel. Reset clears positions, window and sizes
// (80 rows, 160 columns); the line buffer is not cleared and needs no sweep.
module uniform_lbp_3x3_unit #(
	parameter int MAX_COLS = ulbp_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = ulbp_pkg::MAX_ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ulbp_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [ulbp_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ulbp_pkg::PIX_W-1:0]     pixel,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ulbp_pkg::IDX_W-1:0]     lbp_index,
	output logic [ulbp_pkg::POS_W-1:0]     out_row,
	output logic [ulbp_pkg::POS_W-1:0]     out_col,
	output logic                           frame_end
);

	import ulbp_pkg::*;

	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CEW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int REW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

	logic [CFG_W-1:0]   frame_rows_q;
	logic [CFG_W-1:0]   frame_cols_q;
	logic [CEW-1:0]     cols_x;
	logic [CEW-1:0]     cols_eff;
	logic [REW-1:0]     rows_x;
	logic [REW-1:0]     rows_eff;
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic               row_end;
	logic               last_row;
	logic               in_accept;
	logic               s1_valid_q;
	item_ctl_t          ctl_s1;
	logic [RW-1:0]      row_s1;
	logic [CW-1:0]      col_s1;
	pix_t               px_s1;
	logic               ge2_s1;
	logic               fwd_s1;
	pix_t               fwd_prev_s1;
	pix_t               fwd_prev2_s1;
	logic [2*PIX_W-1:0] rd_data;
	pix_t               vm;
	pix_t               vp2;
	pix_t               vt;
	logic               s1_fire;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= ROWS_RST;
			frame_cols_q <= COLS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_ROWS: frame_rows_q <= cfg_data;
				REG_FRAME_COLS: frame_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective frame size: zero acts as one, clamp to the maximum
	always_comb begin
		cols_x = CEW'(frame_cols_q);
		rows_x = REW'(frame_rows_q);
		if (cols_x == '0) begin
			cols_eff = CEW'(1);
		end else if (cols_x > CEW'(MAX_COLS)) begin
			cols_eff = CEW'(MAX_COLS);
		end else begin
			cols_eff = cols_x;
		end
		if (rows_x == '0) begin
			rows_eff = REW'(1);
		end else if (rows_x > REW'(MAX_ROWS)) begin
			rows_eff = REW'(MAX_ROWS);
		end else begin
			rows_eff = rows_x;
		end
	end

	assign row_end   = (CEW'(col_q) + CEW'(1)) >= cols_eff;
	assign last_row  = (REW'(row_q) + REW'(1)) >= rows_eff;
	assign in_ready  = !s1_valid_q || s1_fire;
	assign in_accept = in_valid && in_ready;

	// line buffer data, forwarded when the previous pixel wrote the same column
	assign vm  = fwd_s1 ? fwd_prev_s1 : rd_data[PIX_W-1:0];
	assign vp2 = fwd_s1 ? fwd_prev2_s1 : rd_data[2*PIX_W-1:PIX_W];
	assign vt  = ge2_s1 ? vp2 : vm;

	// raster position and result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				s1_valid_q <= 1'b1;
				if (row_end) begin
					col_q <= '0;
					row_q <= last_row ? '0 : (row_q + 1'b1);
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			px_s1                         <= pixel;
			row_s1                        <= row_q;
			col_s1                        <= col_q;
			ge2_s1                        <= (REW'(row_q) >= REW'(TOP_ROW_MIN));
			ctl_s1.slot[SLOT_UP_MID]      <= (row_q != '0) && (col_q != '0);
			ctl_s1.slot[SLOT_UP_END]      <= (row_q != '0) && row_end;
			ctl_s1.slot[SLOT_LO_MID]      <= last_row && (col_q != '0);
			ctl_s1.slot[SLOT_LO_END]      <= last_row && row_end;
			ctl_s1.col_nz                 <= (col_q != '0);
			ctl_s1.row_nz                 <= (row_q != '0);
			ctl_s1.frame_last             <= last_row && row_end;
			fwd_s1                        <= s1_fire && (col_s1 == col_q);
			fwd_prev_s1                   <= px_s1;
			fwd_prev2_s1                  <= vm;
		end
	end

	// previous two rows: low byte is the row above, high byte two rows up
	ulbp_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_COLS)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (col_s1),
		.wdata ({vm, px_s1}),
		.re    (in_accept),
		.raddr (col_q),
		.rdata (rd_data)
	);

	ulbp_emit #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid_q),
		.s1_ctl    (ctl_s1),
		.s1_row    (row_s1),
		.s1_col    (col_s1),
		.s1_top    (vt),
		.s1_mid    (vm),
		.s1_px     (px_s1),
		.s1_fire   (s1_fire),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.lbp_index (lbp_index),
		.out_row   (out_row),
		.out_col   (out_col),
		.frame_end (frame_end)
	);

endmodule
